### design/ppp_pkg.sv
`default_nettype none
package ppp_pkg;

  // Field and datapath widths.
  localparam int COEF_W         = 32;
  localparam int CLIP_W         = 50;  // clip values stay below 2^49 in magnitude
  localparam int NUM_W          = 64;  // half size times clip value
  localparam int DEN_W          = 48;  // positive clip w
  localparam int QUO_W          = 33;  // quotient bits before saturation
  localparam int MAG_W          = QUO_W + 1;
  localparam int OFF_W          = MAG_W + 2;
  localparam int HALF_W         = 13;
  localparam int WIN_W          = 14;
  localparam int CFG_W          = 31;
  localparam int CFG_IDX_W      = 2;
  localparam int MATRIX_ENTRIES_DEF = 16;

  localparam logic [WIN_W-1:0] WIDTH_RESET  = WIN_W'(1920);
  localparam logic [WIN_W-1:0] HEIGHT_RESET = WIN_W'(1080);
  localparam logic [CFG_W-1:0] MIN_W_RESET  = CFG_W'(6554);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_WIDTH  = 2'd0,
    REG_WINDOW_HEIGHT = 2'd1,
    REG_MIN_CLIP_W    = 2'd2
  } cfg_reg_t;

  // Per-item flags that travel alongside the divider.
  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
    logic zero_x;
    logic zero_y;
  } side_t;

endpackage
`default_nettype wire

### design/ppp_clip.sv
`default_nettype none
module ppp_clip import ppp_pkg::*; #(
  parameter int MATRIX_ENTRIES = MATRIX_ENTRIES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     load,
  input  wire logic [$clog2(MATRIX_ENTRIES)-1:0] coef_index,
  input  wire logic signed [COEF_W-1:0] coef_value,
  input  wire logic signed [COEF_W-1:0] point_x,
  input  wire logic signed [COEF_W-1:0] point_y,
  input  wire logic signed [COEF_W-1:0] point_z,
  output logic signed [CLIP_W-1:0]      clip_x,
  output logic signed [CLIP_W-1:0]      clip_y,
  output logic signed [CLIP_W-1:0]      clip_w
);

  localparam int SUM_W = 2 * COEF_W + 2;

  logic signed [COEF_W-1:0] coef [MATRIX_ENTRIES];
  logic signed [2*COEF_W-1:0] prod [3][3];
  logic signed [COEF_W-1:0] cst [3];
  logic signed [COEF_W-1:0] pt [3];
  logic signed [CLIP_W-1:0] clip_next [3];

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  // Coefficient store, written by load transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MATRIX_ENTRIES; i++) coef[i] <= '0;
    end else if (load) begin
      coef[coef_index] <= coef_value;
    end
  end

  // Stage one: the nine products of rows 0, 1 and 3.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          prod[r][i] <= (2*COEF_W)'(pt[i]) * (2*COEF_W)'(coef[(r == 2 ? 12 : r * 4) + i]);
        end
        cst[r] <= coef[(r == 2 ? 12 : r * 4) + 3];
      end
    end
  end

  // Stage two: exact sum floored to Q16.16 plus the constant column.
  always_comb begin
    logic signed [SUM_W-1:0] s;
    for (int r = 0; r < 3; r++) begin
      s = SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2]);
      s = (s >>> 16) + SUM_W'(cst[r]);
      clip_next[r] = s[CLIP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clip_x <= clip_next[0];
      clip_y <= clip_next[1];
      clip_w <= clip_next[2];
    end
  end

endmodule
`default_nettype wire

### design/ppp_offset.sv
`default_nettype none
module ppp_offset import ppp_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [CLIP_W-1:0] clip_x,
  input  wire logic signed [CLIP_W-1:0] clip_y,
  input  wire logic signed [CLIP_W-1:0] clip_w,
  input  wire logic [HALF_W-1:0]        half_w,
  input  wire logic [HALF_W-1:0]        half_h,
  input  wire logic [CFG_W-1:0]         min_clip_w,
  output logic [DEN_W-1:0]              den,
  output logic [DEN_W-1:0]              rem_x,
  output logic [DEN_W-1:0]              rem_y,
  output logic [QUO_W-1:0]              low_x,
  output logic [QUO_W-1:0]              low_y,
  output side_t                         side
);

  logic signed [NUM_W-1:0] num_x, num_y;
  logic signed [CLIP_W-1:0] w_q;
  logic                     vis_q;
  logic [NUM_W-1:0]         mag_x, mag_y;

  // Stage three: numerators and the visibility test.
  always_ff @(posedge clk) begin
    if (en) begin
      num_x <= NUM_W'(clip_x) * NUM_W'($signed({1'b0, half_w}));
      num_y <= NUM_W'(clip_y) * NUM_W'($signed({1'b0, half_h}));
      w_q   <= clip_w;
      vis_q <= clip_w >= $signed({{(CLIP_W-CFG_W){1'b0}}, min_clip_w});
    end
  end

  assign mag_x = num_x[NUM_W-1] ? NUM_W'(-num_x) : num_x;
  assign mag_y = num_y[NUM_W-1] ? NUM_W'(-num_y) : num_y;

  // Stage four: magnitudes split into the divider start remainder and the
  // bits still to be shifted in, plus the overflow and zero checks.
  always_ff @(posedge clk) begin
    if (en) begin
      den         <= w_q[DEN_W-1:0];
      rem_x       <= DEN_W'(mag_x[NUM_W-1:17]);
      rem_y       <= DEN_W'(mag_y[NUM_W-1:17]);
      low_x       <= {mag_x[16:0], 16'b0};
      low_y       <= {mag_y[16:0], 16'b0};
      side.vis    <= vis_q;
      side.neg_x  <= num_x[NUM_W-1];
      side.neg_y  <= num_y[NUM_W-1];
      side.zero_x <= mag_x == '0;
      side.zero_y <= mag_y == '0;
      side.sat_x  <= (mag_x != '0) && (DEN_W'(mag_x[NUM_W-1:17]) >= w_q[DEN_W-1:0]);
      side.sat_y  <= (mag_y != '0) && (DEN_W'(mag_y[NUM_W-1:17]) >= w_q[DEN_W-1:0]);
    end
  end

endmodule
`default_nettype wire

### design/ppp_div.sv
`default_nettype none
module ppp_div import ppp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic [DEN_W-1:0] rem_in,
  input  wire logic [QUO_W-1:0] low_bits,
  output logic [QUO_W-1:0]      quo
);

  logic [DEN_W-1:0] d_q [QUO_W];
  logic [DEN_W-1:0] r_q [QUO_W];
  logic [QUO_W-1:0] n_q [QUO_W];
  logic [QUO_W-1:0] q_q [QUO_W];

  // One restoring step per stage: shift in a numerator bit, subtract if it fits.
  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W-1:0] d_i, r_i, r_next;
    logic [QUO_W-1:0] n_i, q_i;
    logic [DEN_W:0]   t;
    logic             ge;

    if (k == 0) begin : g_first
      assign d_i = den;
      assign r_i = rem_in;
      assign n_i = low_bits;
      assign q_i = '0;
    end else begin : g_rest
      assign d_i = d_q[k-1];
      assign r_i = r_q[k-1];
      assign n_i = n_q[k-1];
      assign q_i = q_q[k-1];
    end

    assign t      = {r_i, n_i[QUO_W-1]};
    assign ge     = t >= {1'b0, d_i};
    assign r_next = ge ? DEN_W'(t - {1'b0, d_i}) : t[DEN_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        d_q[k] <= d_i;
        r_q[k] <= r_next;
        n_q[k] <= {n_i[QUO_W-2:0], 1'b0};
        q_q[k] <= {q_i[QUO_W-2:0], ge};
      end
    end
  end

  assign quo = q_q[QUO_W-1];

endmodule
`default_nettype wire

### design/perspective_point_projection.sv
// Channel   Direction  tdata (low bit up)                               tuser
// s_        in         coef_index[3:0], coef_value, point_x/y/z, pad    func
// m_        out        screen_x[31:0], screen_y[63:32]                  visible
// cfg       in         we, index 0..2, data[30:0]                       -
//
// One item enters per cycle while the output is free. A project transfer
// passes 38 register stages: four arithmetic stages, the 33-stage restoring
// divider and the output register.
// Load transfers update the matrix at once and give no result.
// A stall on the output freezes the whole pipeline; nothing is lost.
// Reset clears the matrix, restores the registers and empties the pipeline.
`default_nettype none
module perspective_point_projection import ppp_pkg::*; #(
  parameter int MATRIX_ENTRIES = MATRIX_ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [135:0]         s_tdata,   // coef_index, coef_value, x, y, z
  input  wire logic                 s_tuser,   // func
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [63:0]               m_tdata,   // screen_x, screen_y
  output logic                      m_tuser,   // visible
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int LAT = 4 + QUO_W + 1;
  localparam int IDX_W = $clog2(MATRIX_ENTRIES);

  logic [WIN_W-1:0] window_width, window_height;
  logic [CFG_W-1:0] min_clip_w;
  logic             en, acc;
  logic [LAT-1:0]   vld;

  logic signed [CLIP_W-1:0] clip_x, clip_y, clip_w;
  logic [DEN_W-1:0] den, rem_x, rem_y;
  logic [QUO_W-1:0] low_x, low_y, quo_x, quo_y;
  side_t            side, side_d [QUO_W];

  logic [63:0] res_data;
  logic        res_user;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= WIDTH_RESET;
      window_height <= HEIGHT_RESET;
      min_clip_w    <= MIN_W_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_WIDTH:  window_width  <= cfg_data[WIN_W-1:0];
        REG_WINDOW_HEIGHT: window_height <= cfg_data[WIN_W-1:0];
        REG_MIN_CLIP_W:    min_clip_w    <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign acc      = s_tvalid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], acc && s_tuser};
    end
  end
  assign m_tvalid = vld[LAT-1];

  ppp_clip #(.MATRIX_ENTRIES(MATRIX_ENTRIES)) u_clip (
    .clk, .rst, .en,
    .load       (acc && !s_tuser),
    .coef_index (s_tdata[IDX_W-1:0]),
    .coef_value (s_tdata[35:4]),
    .point_x    (s_tdata[67:36]),
    .point_y    (s_tdata[99:68]),
    .point_z    (s_tdata[131:100]),
    .clip_x, .clip_y, .clip_w
  );

  ppp_offset u_offset (
    .clk, .en, .clip_x, .clip_y, .clip_w,
    .half_w (window_width[WIN_W-1:1]),
    .half_h (window_height[WIN_W-1:1]),
    .min_clip_w,
    .den, .rem_x, .rem_y, .low_x, .low_y, .side
  );

  ppp_div u_div_x (.clk, .en, .den, .rem_in(rem_x), .low_bits(low_x), .quo(quo_x));
  ppp_div u_div_y (.clk, .en, .den, .rem_in(rem_y), .low_bits(low_y), .quo(quo_y));

  // Flags follow the divider stage by stage.
  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side;
      for (int k = 1; k < QUO_W; k++) side_d[k] <= side_d[k-1];
    end
  end

  // Final stage: saturate, apply sign, add the viewport centre, clamp to 32 bits, zero hidden points.
  always_comb begin
    side_t                   sd;
    logic [MAG_W-1:0]        mx, my;
    logic signed [OFF_W-1:0] ox, oy, sx, sy;
    logic signed [31:0]      rx, ry;
    sd = side_d[QUO_W-1];
    mx = sd.sat_x ? MAG_W'(1) << QUO_W : (sd.zero_x ? '0 : {1'b0, quo_x});
    my = sd.sat_y ? MAG_W'(1) << QUO_W : (sd.zero_y ? '0 : {1'b0, quo_y});
    ox = sd.neg_x ? -$signed(OFF_W'(mx)) : $signed(OFF_W'(mx));
    oy = sd.neg_y ? -$signed(OFF_W'(my)) : $signed(OFF_W'(my));
    sx = $signed(OFF_W'({window_width[WIN_W-1:1], 16'b0})) + ox;
    sy = $signed(OFF_W'({window_height[WIN_W-1:1], 16'b0})) - oy;
    if (sx > $signed(OFF_W'(32'h7fff_ffff))) rx = 32'sh7fff_ffff;
    else if (sx < -$signed(OFF_W'(33'h0_8000_0000))) rx = 32'sh8000_0000;
    else rx = sx[31:0];
    if (sy > $signed(OFF_W'(32'h7fff_ffff))) ry = 32'sh7fff_ffff;
    else if (sy < -$signed(OFF_W'(33'h0_8000_0000))) ry = 32'sh8000_0000;
    else ry = sy[31:0];
    res_user = sd.vis;
    res_data = sd.vis ? {ry, rx} : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= res_data;
      m_tuser <= res_user;
    end
  end

endmodule
`default_nettype wire

### design/ppp_checker.sv
`default_nettype none
module ppp_props (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic        m_tuser
);

  // The pipeline is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // A point that is not visible reports zero coordinates.
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 64'd0)
    else $error("hidden point with nonzero coordinates");

  // Input is refused exactly when a result waits unaccepted.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output state");

endmodule

bind perspective_point_projection ppp_props u_ppp_props (
  .clk, .rst, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
`default_nettype wire

### bench/ppp_checker.sv
`default_nettype none
module ppp_checker import ppp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_tready,
  input  wire logic [135:0]         s_tdata,   // coef_index, coef_value, x, y, z
  input  wire logic                 s_tuser,   // func
  input  wire logic                 m_tvalid,
  input  wire logic                 m_tready,
  input  wire logic [63:0]          m_tdata,   // screen_x, screen_y
  input  wire logic                 m_tuser,   // visible
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        fail_count,
  output int                        points_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_LOAD = 1'b0;
  localparam longint OFFSET_CAP = longint'(1) << 33;

  typedef struct {
    logic                visible;
    logic signed [31:0]  screen_x;
    logic signed [31:0]  screen_y;
  } screen_point_t;

  logic signed [31:0] coefs [16];
  logic [WIN_W-1:0]   win_width;
  logic [WIN_W-1:0]   win_height;
  logic [CFG_W-1:0]   clip_w_floor;
  screen_point_t      screen_queue [$];

  // One row of the matrix times (x, y, z, 1), floored to Q16.16.
  function automatic longint clip_coord(int row, logic signed [31:0] x,
                                        logic signed [31:0] y, logic signed [31:0] z);
    logic signed [67:0] px, py, pz, acc;
    px = x;
    py = y;
    pz = z;
    acc = px * 68'(coefs[row*4]) + py * 68'(coefs[row*4+1]) + pz * 68'(coefs[row*4+2]);
    return longint'(acc >>> 16) + longint'(coefs[row*4+3]);
  endfunction

  // half * c / w in Q16.16, magnitude truncated and capped.
  function automatic longint viewport_offset(longint half, longint c, longint w);
    longint     n;
    logic       neg;
    logic [127:0] un, mag;
    n = half * c;
    neg = n < 0;
    un = neg ? 128'(-n) : 128'(n);
    if (w <= 0) begin
      if (un == 0) return 0;
      return neg ? -OFFSET_CAP : OFFSET_CAP;
    end
    mag = (un << 16) / 128'(w);
    if (mag > 128'(OFFSET_CAP)) mag = 128'(OFFSET_CAP);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic screen_point_t project_point(logic signed [31:0] x,
                                                  logic signed [31:0] y,
                                                  logic signed [31:0] z);
    screen_point_t sp;
    longint cx, cy, cw, hw, hh;
    cx = clip_coord(0, x, y, z);
    cy = clip_coord(1, x, y, z);
    cw = clip_coord(3, x, y, z);
    sp = '{1'b0, 32'sd0, 32'sd0};
    if (cw >= longint'(clip_w_floor)) begin
      hw = longint'(win_width >> 1);
      hh = longint'(win_height >> 1);
      sp.visible  = 1'b1;
      sp.screen_x = clamp32(hw * 65536 + viewport_offset(hw, cx, cw));
      sp.screen_y = clamp32(hh * 65536 - viewport_offset(hh, cy, cw));
    end
    return sp;
  endfunction

  assign points_pending = screen_queue.size();

  // Track configuration, matrix loads and project transfers; check results.
  always @(posedge clk) begin
    screen_point_t exp_pt;
    if (rst) begin
      foreach (coefs[i]) coefs[i] = '0;
      win_width    = WIDTH_RESET;
      win_height   = HEIGHT_RESET;
      clip_w_floor = MIN_W_RESET;
      screen_queue.delete();
      fail_count   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_WIDTH:  win_width    = cfg_data[WIN_W-1:0];
          REG_WINDOW_HEIGHT: win_height   = cfg_data[WIN_W-1:0];
          REG_MIN_CLIP_W:    clip_w_floor = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == FUNC_LOAD)
          coefs[s_tdata[3:0]] = s_tdata[35:4];
        else
          screen_queue.push_back(project_point(s_tdata[67:36], s_tdata[99:68],
                                               s_tdata[131:100]));
      end
      if (m_tvalid && m_tready) begin
        if (screen_queue.size() == 0) begin
          fail_count++;
          $display("%0t: expected no result, got vis=%b x=%h y=%h", $realtime, m_tuser,
                   m_tdata[31:0], m_tdata[63:32]);
        end else begin
          exp_pt = screen_queue.pop_front();
          if (m_tuser !== exp_pt.visible || m_tdata[31:0] !== exp_pt.screen_x ||
              m_tdata[63:32] !== exp_pt.screen_y) begin
            fail_count++;
            $display("%0t: expected vis=%b x=%h y=%h, got vis=%b x=%h y=%h",
                     $realtime, exp_pt.visible, exp_pt.screen_x, exp_pt.screen_y,
                     m_tuser, m_tdata[31:0], m_tdata[63:32]);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

### bench/tb_perspective_point_projection.sv
`default_nettype none
module tb_perspective_point_projection import ppp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_PROJECT = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int ONE = 65536;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [135:0]         s_tdata;   // coef_index, coef_value, x, y, z
  logic                 s_tuser;   // func
  logic                 m_tvalid;
  logic                 m_tready;
  logic [63:0]          m_tdata;   // screen_x, screen_y
  logic                 m_tuser;   // visible
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   points_pending;
  int                   cycle_count;
  logic                 no_gaps;
  logic                 long_hold_done;

  perspective_point_projection dut (.*);

  ppp_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Overall run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls per result, one long hold to back up the pipeline.
  initial begin
    int stall;
    int results_taken;
    m_tready = 1'b0;
    results_taken = 0;
    @(negedge rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (!long_hold_done && results_taken == 200) begin
        stall = 300;
        long_hold_done = 1'b1;
      end
      repeat (stall) begin
        @(negedge clk);
        m_tready = 1'b0;
      end
      @(negedge clk);
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_taken++;
    end
  end

  // One input transfer, after a random number of idle cycles.
  task automatic send_item(logic func, logic [3:0] idx, logic [31:0] val,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = func;
    s_tdata  = {4'd0, z, y, x, val, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic load_coef(int idx, logic [31:0] val);
    send_item(FUNC_LOAD, 4'(idx), val, $urandom, $urandom, $urandom);
  endtask

  task automatic project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_item(FUNC_PROJECT, 4'($urandom), $urandom, x, y, z);
  endtask

  // Wait for every result, then let loads and the pipeline settle.
  task automatic drain;
    @(negedge clk);
    s_tvalid = 1'b0;
    while (points_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_viewport(int w, int h, logic [CFG_W-1:0] min_w);
    write_reg(REG_WINDOW_WIDTH, CFG_W'(w));
    write_reg(REG_WINDOW_HEIGHT, CFG_W'(h));
    write_reg(REG_MIN_CLIP_W, min_w);
  endtask

  // Small perspective-like matrix with random content.
  task automatic load_sane_matrix;
    for (int i = 0; i < 16; i++) begin
      if (i % 4 == 3) load_coef(i, $urandom_range(0, 8 * ONE) - 4 * ONE);
      else load_coef(i, $urandom_range(0, 4 * ONE) - 2 * ONE);
    end
  endtask

  // Mostly modest points and matrix tweaks, some wide noise.
  task automatic random_items(int count);
    int kind;
    for (int n = 0; n < count; n++) begin
      if (n % 250 == 0) no_gaps = ~no_gaps;
      kind = $urandom_range(0, 99);
      if (kind < 60)
        project($urandom_range(0, 200 * ONE) - 100 * ONE,
                $urandom_range(0, 200 * ONE) - 100 * ONE,
                $urandom_range(0, 200 * ONE) - 100 * ONE);
      else if (kind < 75)
        project($urandom, $urandom, $urandom);
      else if (kind < 92)
        load_coef($urandom_range(0, 15), $urandom_range(0, 4 * ONE) - 2 * ONE);
      else
        load_coef($urandom_range(0, 15), $urandom);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = FUNC_LOAD;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_WINDOW_WIDTH;
    cfg_data = '0;
    cycle_count = 0;
    no_gaps = 1'b0;
    long_hold_done = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero matrix after reset, then a simple perspective setup.
    project(32'h7fffffff, 32'h80000000, 32'd0);
    load_coef(0, ONE);
    load_coef(5, ONE);
    load_coef(14, ONE);
    load_coef(3, 32'h80000000);
    load_coef(7, 32'h7fffffff);
    project(ONE, 2 * ONE, 5 * ONE);
    project(-ONE, -2 * ONE, 5 * ONE);
    project(0, 0, -ONE);
    project(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    project(32'h80000000, 32'h80000000, 32'h80000000);
    project(0, 0, 6554);
    project(0, 0, 6553);
    drain();

    // Zero clip w allowed, tiny and maximum viewports, spare index ignored.
    set_viewport(8192, 8192, '0);
    write_reg(REG_SPARE, '1);
    load_coef(14, 0);
    load_coef(3, 0);
    load_coef(7, 0);
    project(ONE, -ONE, 3 * ONE);
    project(0, 0, 0);
    project(-ONE, ONE, 0);
    drain();
    set_viewport(1, 0, '1);
    load_coef(15, 32'h7fffffff);
    project(ONE, ONE, ONE);
    drain();
    set_viewport(16383, 16383, 1);
    project(5 * ONE, -3 * ONE, 0);
    drain();

    // Random phases through several settings.
    set_viewport(1920, 1080, 6554);
    load_sane_matrix();
    random_items(400);
    drain();
    set_viewport(8192, 8192, '0);
    load_sane_matrix();
    random_items(300);
    drain();
    set_viewport(1, 1, '1);
    random_items(150);
    drain();
    set_viewport($urandom_range(1, 8192), $urandom_range(1, 8192), $urandom_range(0, ONE));
    load_sane_matrix();
    random_items(500);
    drain();

    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
